### design/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSV converter
// Channel and fraction widths, the hue sector code and the record that moves
// along the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;

  // Divisor of the hue quotient is six times the spread.
  localparam int HUE_DIV_BITS = CHANNEL_BITS + 3;

  // Stream widths, padded up to whole bytes.
  localparam int IN_BITS  = ((3 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ((2 * FRACTION_BITS + CHANNEL_BITS + 7) / 8) * 8;

  // Sector offsets: one third and two thirds of a turn, truncated.
  localparam logic [FRACTION_BITS-1:0] HUE_THIRD =
    FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd3);
  localparam logic [FRACTION_BITS-1:0] HUE_TWO_THIRDS =
    FRACTION_BITS'((64'd2 << FRACTION_BITS) / 64'd3);

  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

  // One pixel in flight through the divider cells.
  typedef struct packed {
    logic [CHANNEL_BITS-1:0]  rem_s;    // saturation partial remainder
    logic [CHANNEL_BITS-1:0]  div_s;    // saturation divisor (max)
    logic [HUE_DIV_BITS-1:0]  rem_h;    // hue partial remainder
    logic [HUE_DIV_BITS-1:0]  div_h;    // hue divisor (6 * spread)
    logic [FRACTION_BITS-1:0] q_s;      // saturation quotient so far
    logic [FRACTION_BITS-1:0] q_h;      // hue magnitude quotient so far
    logic [CHANNEL_BITS-1:0]  max_val;  // brightness
    sector_t                  sector;
    logic                     neg;      // channel difference is negative
    logic                     grey;     // zero spread
    logic                     sat_full; // min is zero: saturation is all ones
  } rhc_pipe_t;

endpackage

`default_nettype wire

### design/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front: entry stage of the RGB to HSV converter
// Find max, min, spread and hue sector, and load the divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front
  import rhc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CHANNEL_BITS-1:0] red,
  input  wire logic [CHANNEL_BITS-1:0] green,
  input  wire logic [CHANNEL_BITS-1:0] blue,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output rhc_pipe_t                    out_data
);

  logic                    valid_r;
  rhc_pipe_t               data_r;
  rhc_pipe_t               data_nxt;
  logic [CHANNEL_BITS-1:0] mx;
  logic [CHANNEL_BITS-1:0] mn;
  logic [CHANNEL_BITS-1:0] spread;
  logic [CHANNEL_BITS-1:0] da;
  logic [CHANNEL_BITS-1:0] db;
  sector_t                 sec;

  always_comb begin
    // Ties go to red, then green.
    priority if (red >= green && red >= blue) begin
      sec = SEC_RED;
      mx  = red;
      da  = green;
      db  = blue;
    end else if (green >= blue) begin
      sec = SEC_GREEN;
      mx  = green;
      da  = blue;
      db  = red;
    end else begin
      sec = SEC_BLUE;
      mx  = blue;
      da  = red;
      db  = green;
    end

    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    spread = mx - mn;

    data_nxt.rem_s    = spread;
    data_nxt.div_s    = mx;
    data_nxt.neg      = (da < db);
    data_nxt.rem_h    = HUE_DIV_BITS'((da < db) ? (db - da) : (da - db));
    data_nxt.div_h    = (HUE_DIV_BITS'(spread) << 2) + (HUE_DIV_BITS'(spread) << 1);
    data_nxt.q_s      = '0;
    data_nxt.q_h      = '0;
    data_nxt.max_val  = mx;
    data_nxt.sector   = sec;
    data_nxt.grey     = (spread == '0);
    data_nxt.sat_full = (mn == '0);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

### design/rhc_div_cell.sv
// ----------------------------------------------------------------------------
// rhc_div_cell: one restoring division step for saturation and hue
// Double both remainders, subtract the divisor where it fits, shift in a bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_cell
  import rhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rhc_pipe_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output rhc_pipe_t       out_data
);

  logic                    valid_r;
  rhc_pipe_t               data_r;
  rhc_pipe_t               data_nxt;
  logic [CHANNEL_BITS:0]   rem2_s;
  logic [HUE_DIV_BITS:0]   rem2_h;
  logic                    fit_s;
  logic                    fit_h;

  always_comb begin
    rem2_s = {in_data.rem_s, 1'b0};
    rem2_h = {in_data.rem_h, 1'b0};
    fit_s  = (rem2_s >= {1'b0, in_data.div_s});
    fit_h  = (rem2_h >= {1'b0, in_data.div_h});

    data_nxt       = in_data;
    data_nxt.rem_s = fit_s ? CHANNEL_BITS'(rem2_s - {1'b0, in_data.div_s})
                           : CHANNEL_BITS'(rem2_s);
    data_nxt.rem_h = fit_h ? HUE_DIV_BITS'(rem2_h - {1'b0, in_data.div_h})
                           : HUE_DIV_BITS'(rem2_h);
    data_nxt.q_s   = {in_data.q_s[FRACTION_BITS-2:0], fit_s};
    data_nxt.q_h   = {in_data.q_h[FRACTION_BITS-2:0], fit_h};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

### design/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back: result stage of the RGB to HSV converter
// Apply sign and sector offset to hue, clamp saturation, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_back
  import rhc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire rhc_pipe_t                in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [FRACTION_BITS-1:0]      hue,
  output logic [FRACTION_BITS-1:0]      saturation,
  output logic [CHANNEL_BITS-1:0]       brightness
);

  logic                     valid_r;
  logic [FRACTION_BITS-1:0] hue_r;
  logic [FRACTION_BITS-1:0] sat_r;
  logic [CHANNEL_BITS-1:0]  bright_r;
  logic [FRACTION_BITS-1:0] hue_nxt;
  logic [FRACTION_BITS-1:0] sat_nxt;
  logic [FRACTION_BITS-1:0] offset;
  logic [FRACTION_BITS-1:0] delta;

  always_comb begin
    unique case (in_data.sector)
      SEC_RED:   offset = '0;
      SEC_GREEN: offset = HUE_THIRD;
      SEC_BLUE:  offset = HUE_TWO_THIRDS;
      default:   offset = '0;
    endcase
    // Quotient is a magnitude; negate for truncation toward zero, wrap a turn.
    delta = in_data.neg ? (~in_data.q_h + 1'b1) : in_data.q_h;

    if (in_data.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = offset + delta;
      sat_nxt = in_data.sat_full ? '1 : in_data.q_s;
    end
  end

  assign in_ready   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign brightness = bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= in_data.max_val;
    end
  end

endmodule

`default_nettype wire

### design/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core: pipelined RGB to HSV pixel converter
// Converts a pixel per clock unless stalled, via a chain of radix-2 divider cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream  in_tdata  = {blue, green, red}, 8 bits each, red lowest.
//   Output stream out_tdata = {brightness, saturation, hue}, hue lowest;
//   hue and saturation are unsigned Q0.16, brightness is the largest channel.
//   A request moves when tvalid and tready are both high.
// Stages: one entry stage for max/min/sector, one divider cell per
//   quotient bit, one result stage.
// Throughput: one pixel per clock unless stalled. Each divider cell resolves
//   one bit of both the saturation and the hue quotient and passes it on.
// Stall: every stage holds its request while the next one is full and
//   stalled; empty stages upstream keep filling, so the input stays ready
//   until the whole chain is occupied. Nothing is dropped or repeated.
// Reset: rst_n low (synchronous) empties every stage; out_tvalid falls.
// Grey pixels (zero spread) give hue 0 and saturation 0; any other pixel whose
//   smallest channel is zero gives saturation all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_core
  import rhc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [IN_BITS-1:0]  in_tdata,   // red, green, blue
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_BITS-1:0]      out_tdata   // hue, saturation, brightness
);

  // Handshake and record at each link of the chain; link 0 leaves the
  // entry stage, link FRACTION_BITS enters the result stage.
  logic      link_valid [FRACTION_BITS+1];
  logic      link_ready [FRACTION_BITS+1];
  rhc_pipe_t link_data  [FRACTION_BITS+1];

  logic [FRACTION_BITS-1:0] hue;
  logic [FRACTION_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0]  brightness;

  // Entry: sort channels, pick sector, load divider operands.
  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .red       (in_tdata[CHANNEL_BITS-1:0]),
    .green     (in_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
    .blue      (in_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link_data[0])
  );

  // Divider chain: first cell yields the most significant quotient bit.
  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  // Result: sign, sector offset, clamp; output register.
  rhc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (link_valid[FRACTION_BITS]),
    .in_ready   (link_ready[FRACTION_BITS]),
    .in_data    (link_data[FRACTION_BITS]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  // Pack with zero fill up to whole bytes.
  assign out_tdata = OUT_BITS'({brightness, saturation, hue});

  // A nonzero spread always gives nonzero saturation, so zero saturation
  // means a grey pixel and the hue must be zero too.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (saturation == '0) |-> (hue == '0))
    else $error("zero saturation with nonzero hue");

  // Black has no spread.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (brightness == '0) |-> (saturation == '0))
    else $error("black pixel with nonzero saturation");

  // Reset empties the chain.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The entry stage refuses a request only when it holds one stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> link_valid[0] && !link_ready[0])
    else $error("input stalled with entry stage free");

endmodule

`default_nettype wire
